// ===== rtl/lpws_pkg.sv =====
// Package for the LED pulse-width serializer.
// Holds register codes, reset values, field widths and the segment record.
// No dependencies.
package lpws_pkg;

   // field widths
   localparam int unsigned PixelWidth  = 8;
   localparam int unsigned TickWidth   = 16;
   localparam int unsigned ResetWidth  = 10;
   localparam int unsigned SegWidth    = 26;
   localparam int unsigned CsrIdxWidth = 8;
   localparam int unsigned CsrDatWidth = 16;
   localparam int unsigned RspDatWidth = 32;

   // segment index: 0 is the reset segment, 1..16 are the bit segments
   localparam int unsigned SegIdxWidth = 5;
   localparam logic [SegIdxWidth-1:0] SegReset = 5'd0;
   localparam logic [SegIdxWidth-1:0] SegFirst = 5'd1;
   localparam logic [SegIdxWidth-1:0] SegFinal = 5'd16;

   // register reset values
   localparam logic [TickWidth-1:0]  BitPeriodReset = 16'd90;
   localparam logic [TickWidth-1:0]  T0HighReset    = 16'd29;
   localparam logic [TickWidth-1:0]  T1HighReset    = 16'd58;
   localparam logic [ResetWidth-1:0] ResetPerReset  = 10'd225;

   // register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_BIT_PERIOD    = 8'd0,
      CSR_T0_HIGH       = 8'd1,
      CSR_T1_HIGH       = 8'd2,
      CSR_RESET_PERIODS = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [TickWidth-1:0]  bit_period_ticks;
      logic [TickWidth-1:0]  t0_high_ticks;
      logic [TickWidth-1:0]  t1_high_ticks;
      logic [ResetWidth-1:0] reset_periods;
   } cfg_type;

   typedef struct packed {
      logic                line_level;
      logic [SegWidth-1:0] segment_ticks;
      logic                run_last;
      logic                frame_done;
   } segment_type;

endpackage

// ===== rtl/led_pulse_width_serializer_core.sv =====
// Segments come from the byte held in lpws_gen and leave through the output register.
// Throughput: 17 segments for a byte that opens a frame, 16 otherwise, one segment per
// cycle unless the response stalls; the next byte is taken as the last segment leaves.
// Reset: timing registers return to 90/29/58 ticks and 225 periods, no frame is open,
// no data held.
// Top level of the LED pulse-width serializer; uses lpws_pkg, lpws_cfg,
// lpws_gen and lpws_out.
module led_pulse_width_serializer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lpws_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [lpws_pkg::CsrDatWidth-1:0]     csr_data,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lpws_pkg::PixelWidth-1:0]      req_tdata,  // [7:0] pixel_byte
   input  logic                                 req_tlast,  // frame_last
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lpws_pkg::RspDatWidth-1:0]     rsp_tdata,  // [0] line_level, [26:1] segment_ticks
   output logic                                 rsp_tlast,  // run_last
   output logic                                 rsp_tuser   // frame_done
);
   import lpws_pkg::*;

   cfg_type     cfg;
   segment_type seg;
   segment_type rsp_seg;
   logic        seg_valid;
   logic        seg_ready;

   lpws_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lpws_gen u_gen (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .pixel_byte (req_tdata),
      .frame_last (req_tlast),
      .seg_valid  (seg_valid),
      .seg_ready  (seg_ready),
      .seg        (seg)
   );

   lpws_out u_out (
      .clock      (clock),
      .reset      (reset),
      .seg_valid  (seg_valid),
      .seg_ready  (seg_ready),
      .seg        (seg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_seg    (rsp_seg)
   );

   // pack the response fields, zero fill to whole bytes
   assign rsp_tdata = {(RspDatWidth-SegWidth-1)'(0), rsp_seg.segment_ticks,
                       rsp_seg.line_level};
   assign rsp_tlast = rsp_seg.run_last;
   assign rsp_tuser = rsp_seg.frame_done;

endmodule

// ===== rtl/lpws_cfg.sv =====
// Configuration registers of the LED pulse-width serializer.
// Decodes the write channel into the four timing registers.
// Depends on lpws_pkg.
module lpws_cfg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lpws_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [lpws_pkg::CsrDatWidth-1:0]     csr_data,
   output lpws_pkg::cfg_type                    cfg
);
   import lpws_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode writes, mask each value to its register width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BIT_PERIOD:    cfg_in.bit_period_ticks = csr_data;
            CSR_T0_HIGH:       cfg_in.t0_high_ticks    = csr_data;
            CSR_T1_HIGH:       cfg_in.t1_high_ticks    = csr_data;
            CSR_RESET_PERIODS: cfg_in.reset_periods    = csr_data[ResetWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period_ticks <= BitPeriodReset;
         cfg_ff.t0_high_ticks    <= T0HighReset;
         cfg_ff.t1_high_ticks    <= T1HighReset;
         cfg_ff.reset_periods    <= ResetPerReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

// ===== rtl/lpws_gen.sv =====
// Segment generator of the LED pulse-width serializer.
// Holds one byte; steps through its segments (reset segment at frame start) one per cycle unless stalled.
// Depends on lpws_pkg.
module lpws_gen (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lpws_pkg::cfg_type                    cfg,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lpws_pkg::PixelWidth-1:0]      pixel_byte,
   input  logic                                 frame_last,
   output logic                                 seg_valid,
   input  logic                                 seg_ready,
   output lpws_pkg::segment_type                seg
);
   import lpws_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   in_frame_ff, in_frame_in;
   logic [SegIdxWidth-1:0] idx_ff, idx_in;
   logic [PixelWidth-1:0]  byte_ff;
   logic                   last_ff;

   logic                   accept;
   logic                   advance;
   logic                   final_seg;
   logic [SegIdxWidth-1:0] seg_num;
   logic                   bit_val;
   logic [TickWidth-1:0]   high_ticks;
   logic [TickWidth-1:0]   low_ticks;

   // request handshake: free slot, or the held byte leaves this cycle
   assign advance    = busy_ff && seg_ready;
   assign final_seg  = (idx_ff == SegFinal);
   assign req_tready = !busy_ff || (advance && final_seg);
   assign accept     = req_tvalid && req_tready;

   // next state of the sequencer
   always_comb begin
      busy_in     = busy_ff;
      idx_in      = idx_ff;
      in_frame_in = in_frame_ff;
      if (advance) begin
         idx_in = idx_ff + SegFirst;
         if (final_seg) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in     = 1'b1;
         idx_in      = in_frame_ff ? SegFirst : SegReset;
         in_frame_in = !frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         in_frame_ff <= 1'b0;
         idx_ff      <= SegReset;
      end else begin
         busy_ff     <= busy_in;
         in_frame_ff <= in_frame_in;
         idx_ff      <= idx_in;
      end
   end

   // hold the byte payload
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= pixel_byte;
         last_ff <= frame_last;
      end
   end

   // pick the bit, MSB first; even offsets are high segments
   assign seg_num    = idx_ff - SegFirst;
   assign bit_val    = byte_ff[~seg_num[3:1]];
   assign high_ticks = bit_val ? cfg.t1_high_ticks : cfg.t0_high_ticks;
   assign low_ticks  = (high_ticks < cfg.bit_period_ticks) ?
                       (cfg.bit_period_ticks - high_ticks) : '0;

   // build the current segment
   always_comb begin
      seg.line_level = 1'b0;
      seg.run_last   = 1'b0;
      seg.frame_done = 1'b0;
      if (idx_ff == SegReset) begin
         seg.segment_ticks = SegWidth'(cfg.reset_periods) * SegWidth'(cfg.bit_period_ticks);
      end else if (!seg_num[0]) begin
         seg.line_level    = 1'b1;
         seg.segment_ticks = SegWidth'(high_ticks);
      end else begin
         seg.segment_ticks = SegWidth'(low_ticks);
         seg.run_last      = final_seg;
         seg.frame_done    = final_seg && last_ff;
      end
   end

   assign seg_valid = busy_ff;

   // index stays within the segment range while a byte is held
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= SegFinal))
      else $error("segment index out of range");

   // a byte that closes a frame leaves the frame closed
   assert property (@(posedge clock) disable iff (reset)
      (accept && frame_last) |=> !in_frame_ff)
      else $error("frame not closed after last byte");

   // a byte opening a frame starts with the reset segment
   assert property (@(posedge clock) disable iff (reset)
      (accept && !in_frame_ff) |=> (idx_ff == SegReset))
      else $error("reset segment skipped at frame start");

   // the slot frees only after the final segment is taken
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !(advance && final_seg)) |=> busy_ff)
      else $error("byte dropped before its final segment");

endmodule

// ===== rtl/lpws_out.sv =====
// Output register of the LED pulse-width serializer.
// Registers each segment and holds it until the response side takes it.
// Depends on lpws_pkg.
module lpws_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    seg_valid,
   output logic                    seg_ready,
   input  lpws_pkg::segment_type   seg,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output lpws_pkg::segment_type   rsp_seg
);
   import lpws_pkg::*;

   logic        valid_ff, valid_in;
   segment_type seg_ff;

   // take a new segment when empty or when the held one leaves
   assign seg_ready = !valid_ff || rsp_tready;
   assign valid_in  = seg_ready ? seg_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seg_ready && seg_valid) begin
         seg_ff <= seg;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_seg    = seg_ff;

endmodule

// ===== tb/sv/led_pulse_width_serializer_core_test.sv =====
// Testbench for led_pulse_width_serializer_core: sends pixel bytes and frames, predicts
// every line segment in SystemVerilog and compares the response stream segment by segment.
// Depends on lpws_pkg and the serializer RTL only.
module led_pulse_width_serializer_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lpws_pkg::*;

   localparam int QuietLimit   = 2000;
   localparam int ReportLimit  = 10;
   localparam int RandomItems  = 160;
   localparam int ItemsPerSet  = 10;
   localparam int DrainCycles  = 20;
   // any index above the last register is ignored by the block
   localparam logic [CsrIdxWidth-1:0] CsrIndexSpare = 8'hFF;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index   = '0;
   logic [CsrDatWidth-1:0] csr_data    = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [PixelWidth-1:0]  req_tdata   = '0;  // [7:0] pixel_byte
   logic                   req_tlast   = 1'b0;  // frame_last
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RspDatWidth-1:0] rsp_tdata;  // [0] line_level, [26:1] segment_ticks
   logic                   rsp_tlast;  // run_last
   logic                   rsp_tuser;  // frame_done

   // predictor state: timing registers, open-frame flag and pending segments
   cfg_type     line_cfg;
   bit          frame_open;
   segment_type segments_due[$];
   int          mismatch_count = 0;
   bit          no_gaps = 1'b0;

   led_pulse_width_serializer_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Queue the line segments one pixel byte produces: an optional reset gap, then
   // a high and a low segment per bit, most significant bit first.
   function automatic void queue_line_segments(input logic [PixelWidth-1:0] pixel,
                                               input logic frame_last);
      segment_type seg;
      logic [TickWidth-1:0] high;
      if (!frame_open) begin
         seg.line_level    = 1'b0;
         seg.segment_ticks = SegWidth'(line_cfg.reset_periods)
                             * SegWidth'(line_cfg.bit_period_ticks);
         seg.run_last      = 1'b0;
         seg.frame_done    = 1'b0;
         segments_due.push_back(seg);
         frame_open = 1'b1;
      end
      for (int b = PixelWidth - 1; b >= 0; b--) begin
         high = pixel[b] ? line_cfg.t1_high_ticks : line_cfg.t0_high_ticks;
         seg.line_level    = 1'b1;
         seg.segment_ticks = SegWidth'(high);
         seg.run_last      = 1'b0;
         seg.frame_done    = 1'b0;
         segments_due.push_back(seg);
         // low time fills the cell, clamped at zero when the high time overruns it
         seg.line_level    = 1'b0;
         seg.segment_ticks = (high < line_cfg.bit_period_ticks)
                             ? SegWidth'(line_cfg.bit_period_ticks - high) : '0;
         seg.run_last      = (b == 0);
         seg.frame_done    = (b == 0) && frame_last;
         segments_due.push_back(seg);
      end
      if (frame_last)
         frame_open = 1'b0;
   endfunction

   // Send one pixel byte, with random gaps unless gaps are off; valid stays high
   // after acceptance until the next falling edge decides.
   task automatic send_pixel(input logic [PixelWidth-1:0] pixel, input logic frame_last);
      @(negedge clock);
      while (!no_gaps && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      req_tlast  <= frame_last;
      do @(posedge clock); while (!req_tready);
      queue_line_segments(pixel, frame_last);
   endtask

   // Drop the request and wait until every predicted segment has come back.
   task automatic wait_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (segments_due.size() != 0) @(posedge clock);
   endtask

   // Write one timing register and mirror it into the predictor.
   task automatic write_reg(input logic [CsrIdxWidth-1:0] index,
                            input logic [CsrDatWidth-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_BIT_PERIOD:    line_cfg.bit_period_ticks = value;
         CSR_T0_HIGH:       line_cfg.t0_high_ticks    = value;
         CSR_T1_HIGH:       line_cfg.t1_high_ticks    = value;
         CSR_RESET_PERIODS: line_cfg.reset_periods    = value[ResetWidth-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_timing(input logic [CsrDatWidth-1:0] period,
                               input logic [CsrDatWidth-1:0] t0_high,
                               input logic [CsrDatWidth-1:0] t1_high,
                               input logic [CsrDatWidth-1:0] gap_periods);
      write_reg(CSR_BIT_PERIOD, period);
      write_reg(CSR_T0_HIGH, t0_high);
      write_reg(CSR_T1_HIGH, t1_high);
      write_reg(CSR_RESET_PERIODS, gap_periods);
   endtask

   // Frames under the reset timing.
   task automatic test_default_timing();
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hFF, 1'b1);
      send_pixel(8'hA5, 1'b1);
   endtask

   // Single-bit and alternating patterns to check bit order.
   task automatic test_bit_order();
      send_pixel(8'h80, 1'b0);
      send_pixel(8'h01, 1'b0);
      send_pixel(8'hAA, 1'b0);
      send_pixel(8'h55, 1'b1);
      send_pixel(8'h7F, 1'b1);
   endtask

   // Register extremes, overrun high time, zero period, zero reset gap,
   // width masking, ignored index and a timing change inside an open frame.
   task automatic test_register_extremes();
      wait_drain();
      write_timing(16'hFFFF, 16'h0000, 16'hFFFF, 16'h03FF);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b1);
      wait_drain();
      write_reg(CSR_BIT_PERIOD, 16'h0000);
      send_pixel(8'h3C, 1'b1);
      wait_drain();
      write_timing(16'd100, 16'd150, 16'd100, 16'd0);
      send_pixel(8'hC3, 1'b1);
      wait_drain();
      write_timing(16'd1, 16'd0, 16'd1, 16'hFFFF);
      write_reg(CsrIndexSpare, 16'h0000);
      send_pixel(8'h5A, 1'b1);
      wait_drain();
      write_timing(16'd90, 16'd29, 16'd58, 16'd225);
      send_pixel(8'h11, 1'b0);
      wait_drain();
      write_reg(CSR_T1_HIGH, 16'd70);
      send_pixel(8'h22, 1'b1);
   endtask

   // Random timing sets, each followed by random frames; frames may stay open
   // across a timing change and a few end flags are random.
   task automatic test_random_frames();
      int sent;
      int set_no;
      int frame_len;
      int pos;
      logic [CsrDatWidth-1:0] period;
      logic [CsrDatWidth-1:0] t0_high;
      logic [CsrDatWidth-1:0] t1_high;
      logic [CsrDatWidth-1:0] gap_periods;
      sent   = 0;
      set_no = 0;
      while (sent < RandomItems) begin
         wait_drain();
         no_gaps = (set_no >= 5 && set_no < 9);
         case (set_no % 4)
            0: begin
               period  = CsrDatWidth'($urandom_range(200, 20));
               t0_high = CsrDatWidth'($urandom_range(period / 3, 1));
               t1_high = CsrDatWidth'($urandom_range(period - 1, period / 3 + 1));
               gap_periods = CsrDatWidth'($urandom_range(300));
            end
            1: begin
               period      = CsrDatWidth'($urandom);
               t0_high     = CsrDatWidth'($urandom);
               t1_high     = CsrDatWidth'($urandom);
               gap_periods = CsrDatWidth'($urandom);
            end
            2: begin
               period      = CsrDatWidth'($urandom_range(50));
               t0_high     = CsrDatWidth'($urandom_range(16'hFFFF, period));
               t1_high     = CsrDatWidth'($urandom);
               gap_periods = CsrDatWidth'($urandom_range(3));
            end
            default: begin
               period      = $urandom_range(1) ? 16'hFFFF : CsrDatWidth'($urandom_range(1));
               t0_high     = $urandom_range(1) ? 16'hFFFE : CsrDatWidth'($urandom_range(1));
               t1_high     = $urandom_range(1) ? 16'hFFFF : 16'h0000;
               gap_periods = $urandom_range(1) ? 16'h03FF : 16'h0000;
            end
         endcase
         write_timing(period, t0_high, t1_high, gap_periods);
         if ($urandom_range(2) == 0)
            write_reg(CsrIdxWidth'($urandom_range(255, 4)), CsrDatWidth'($urandom));
         frame_len = 0;
         pos       = 0;
         for (int i = 0; i < ItemsPerSet && sent < RandomItems; i++) begin
            if (pos == frame_len) begin
               frame_len = $urandom_range(6, 1);
               pos       = 0;
            end
            pos++;
            if ($urandom_range(7) == 0)
               send_pixel(PixelWidth'($urandom), 1'($urandom));
            else
               send_pixel(PixelWidth'($urandom), pos == frame_len);
            sent++;
         end
         set_no++;
      end
      no_gaps = 1'b0;
   endtask

   // Response side: stall at random except during the gap-free stretch.
   always @(negedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(99) >= 20);
   end

   // Compare each accepted segment with the oldest prediction.
   always @(posedge clock) begin : check_segments
      segment_type seen;
      segment_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.line_level    = rsp_tdata[0];
         seen.segment_ticks = rsp_tdata[SegWidth:1];
         seen.run_last      = rsp_tlast;
         seen.frame_done    = rsp_tuser;
         if (segments_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
               $display("unexpected segment: level %0b ticks %0d run_last %0b frame_done %0b",
                        seen.line_level, seen.segment_ticks, seen.run_last, seen.frame_done);
         end else begin
            due = segments_due.pop_front();
            if (seen.line_level !== due.line_level || seen.segment_ticks !== due.segment_ticks
                || seen.run_last !== due.run_last || seen.frame_done !== due.frame_done) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit) begin
                  $display("segment mismatch at %0t", $realtime);
                  $display("  expected level %0b ticks %0d run_last %0b frame_done %0b",
                           due.line_level, due.segment_ticks, due.run_last, due.frame_done);
                  $display("  actual   level %0b ticks %0d run_last %0b frame_done %0b",
                           seen.line_level, seen.segment_ticks, seen.run_last,
                           seen.frame_done);
               end
            end
         end
      end
   end

   // End the run when no handshake of any kind happens for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      line_cfg.bit_period_ticks = BitPeriodReset;
      line_cfg.t0_high_ticks    = T0HighReset;
      line_cfg.t1_high_ticks    = T1HighReset;
      line_cfg.reset_periods    = ResetPerReset;
      frame_open                = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_default_timing();
      test_bit_order();
      test_register_extremes();
      test_random_frames();

      // hold off for stray segments after the last prediction is met
      wait_drain();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && segments_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
